>>> rtl/bilup_pkg.sv
// shared constants, types and the pixel blend for the bilinear upscaler
`default_nettype none

package bilup_pkg;

  // source image size defaults
  localparam int unsigned SRC_WIDTH_DEF  = 640;
  localparam int unsigned SRC_HEIGHT_DEF = 480;

  // configuration register widths and reset values
  localparam int unsigned CFG_W          = 13;
  localparam logic [CFG_W-1:0] OUT_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] OUT_HEIGHT_RST = 13'd480;

  // register index, taken from paddr bit 2
  localparam logic REG_OUT_WIDTH  = 1'b0;
  localparam logic REG_OUT_HEIGHT = 1'b1;

  // item kinds carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // one quotient bit per divider stage, quotient bounded by the 13-bit row term
  localparam int unsigned DIV_STAGES = 13;

  localparam logic [31:0] ALPHA    = 32'hFF00_0000;
  localparam int unsigned HALF_ONE = 32768;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_STEP_X,
    DIV_OFF_X,
    DIV_Y
  } div_state_e;

  // weighted mix of two pixels, each channel truncated separately
  function automatic logic [23:0] blend(input logic [23:0] p, input logic [23:0] q,
                                        input logic [7:0] wq);
    logic [8:0]  wp;
    logic [23:0] r;
    wp = 9'd256 - {1'b0, wq};
    for (int c = 0; c < 3; c++) begin
      r[c*8 +: 8] = 8'((17'(p[c*8 +: 8]) * 17'(wp) + 17'(q[c*8 +: 8]) * 17'(wq)) >> 8);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bilup_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module bilup_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/bilinear_image_upscaler.sv
// top level of the bilinear image upscaler: mapping pipeline, source store, apb registers
`default_nettype none

// Holds a SRC_WIDTH x SRC_HEIGHT image of 24-bit RGB pixels. An item with tuser = 0 writes one
// source pixel (out-of-range writes are dropped); an item with tuser = 1 asks for destination
// pixel (dst_x, dst_y) of an out_width x out_height image and yields one ARGB pixel, alpha 0xFF.
// A new item is taken every cycle while the divider is idle and the pipeline has room; a read
// result passes 20 register stages: the input stage, the 13-stage per-item divider for the
// row position and six mapping, memory and blend stages.
// Backpressure stalls only the stages that are full. After reset and after every register
// write the block recomputes its column step, column offset and row factors with a shared
// bit-serial divider and accepts no item until all three divisions are done.
// The source store is four copies of the image so that all four neighbours read in the same cycle;
// reading a pixel that was never written gives an undefined result.
module bilinear_image_upscaler #(
  parameter int unsigned SRC_WIDTH  = bilup_pkg::SRC_WIDTH_DEF,
  parameter int unsigned SRC_HEIGHT = bilup_pkg::SRC_HEIGHT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // stream in
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  // src_x[9:0], src_y[18:10], src_rgb[42:19], dst_x[54:43], dst_y[66:55], zero pad
  input  wire logic [71:0] s_tdata_i,
  // op[0]
  input  wire logic [0:0]  s_tuser_i,
  // stream out
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  // out_pixel[31:0]
  output logic      [31:0] m_tdata_o,
  // apb registers
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic      [31:0] prdata_o,
  output logic             pready_o
);

  import bilup_pkg::*;

  // widths derived from the image size
  localparam int unsigned MAX_SZ = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
  localparam int unsigned SZ_W   = $clog2(MAX_SZ + 1);
  localparam int unsigned NUM_W  = SZ_W + 16;          // SZ_W.16 numerators and quotients
  localparam int unsigned CNT_W  = $clog2(NUM_W);
  localparam int unsigned XW     = $clog2(SRC_WIDTH);
  localparam int unsigned YW     = $clog2(SRC_HEIGHT);
  localparam int unsigned DEPTH  = SRC_WIDTH * SRC_HEIGHT;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned PXW    = 12 + NUM_W;         // dst_x * step
  localparam int unsigned PYW    = 13 + NUM_W;         // (2 dst_y + 1) * row quotient
  localparam int unsigned SXW    = PXW + 1;
  localparam int unsigned SYW    = PYW + 1;
  localparam int unsigned QW     = DIV_STAGES;

  // stage numbering
  localparam int unsigned ST_F   = DIV_STAGES + 1;     // position sums
  localparam int unsigned ST_C   = DIV_STAGES + 2;     // clamp and split
  localparam int unsigned ST_A   = DIV_STAGES + 3;     // row bases, memory address
  localparam int unsigned ST_M   = DIV_STAGES + 4;     // memory data
  localparam int unsigned ST_H   = DIV_STAGES + 5;     // horizontal blend
  localparam int unsigned ST_O   = DIV_STAGES + 6;     // output register
  localparam int unsigned NST    = DIV_STAGES + 7;

  localparam logic [SXW-1:0] MAX_X  = SXW'(SRC_WIDTH - 1) << 16;
  localparam logic [SYW-1:0] MAX_Y  = SYW'(SRC_HEIGHT - 1) << 16;
  localparam logic [SXW-1:0] HALF_X = SXW'(HALF_ONE);
  localparam logic [SYW-1:0] HALF_Y = SYW'(HALF_ONE);

  typedef struct packed {
    logic             op;
    logic             wen;
    logic [AW-1:0]    waddr;
    logic [23:0]      wdata;
  } side_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] out_width_q, out_height_q;
  logic             cfg_we;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_width_q  <= OUT_WIDTH_RST;
      out_height_q <= OUT_HEIGHT_RST;
    end else if (cfg_we) begin
      if (paddr_i[2] == REG_OUT_WIDTH) begin
        out_width_q <= pwdata_i[CFG_W-1:0];
      end else begin
        out_height_q <= pwdata_i[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    case (paddr_i[2])
      REG_OUT_WIDTH:  prdata_o = 32'(out_width_q);
      REG_OUT_HEIGHT: prdata_o = 32'(out_height_q);
      default:        prdata_o = '0;
    endcase
  end

  // zero size behaves as one
  logic [CFG_W-1:0] w_eff, h_eff;
  assign w_eff = (out_width_q  == '0) ? CFG_W'(1) : out_width_q;
  assign h_eff = (out_height_q == '0) ? CFG_W'(1) : out_height_q;

  // ---------------------------------------------------------------------------
  // bit-serial divider for the size-dependent factors
  // ---------------------------------------------------------------------------
  div_state_e         div_state_q, div_state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CFG_W-1:0]   rem_q, rem_d;
  logic [NUM_W-1:0]   quo_q, quo_d;
  logic [NUM_W-1:0]   num;
  logic [CFG_W-1:0]   divisor;
  logic [CFG_W:0]     trial;
  logic               ge, last, busy;
  logic [NUM_W-1:0]   step_x_q, off_x_q, q_y_q;
  logic [CFG_W-1:0]   r_y_q;

  assign busy = (div_state_q != DIV_IDLE);
  assign last = (cnt_q == CNT_W'(NUM_W - 1));

  // next state
  always_comb begin
    div_state_d = div_state_q;
    if (cfg_we) begin
      div_state_d = DIV_STEP_X;
    end else if (last) begin
      case (div_state_q)
        DIV_STEP_X: div_state_d = DIV_OFF_X;
        DIV_OFF_X:  div_state_d = DIV_Y;
        DIV_Y:      div_state_d = DIV_IDLE;
        default:    div_state_d = DIV_IDLE;
      endcase
    end
  end

  // divider datapath
  always_comb begin
    case (div_state_q)
      DIV_STEP_X: num = NUM_W'(SRC_WIDTH) << 16;
      DIV_OFF_X:  num = NUM_W'(SRC_WIDTH) << 15;
      DIV_Y:      num = NUM_W'(SRC_HEIGHT) << 15;
      default:    num = '0;
    endcase
    divisor = (div_state_q == DIV_Y) ? h_eff : w_eff;
    trial   = {rem_q, num[CNT_W'(NUM_W - 1) - cnt_q]};
    ge      = (trial >= {1'b0, divisor});
    rem_d   = ge ? CFG_W'(trial - {1'b0, divisor}) : trial[CFG_W-1:0];
    quo_d   = {quo_q[NUM_W-2:0], ge};
    cnt_d   = (last || !busy || cfg_we) ? '0 : cnt_q + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_state_q <= DIV_STEP_X;
      cnt_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
    end else begin
      div_state_q <= div_state_d;
      cnt_q       <= cnt_d;
      if (last || !busy || cfg_we) begin
        rem_q <= '0;
        quo_q <= '0;
      end else begin
        rem_q <= rem_d;
        quo_q <= quo_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy && last && !cfg_we) begin
      case (div_state_q)
        DIV_STEP_X: step_x_q <= quo_d;
        DIV_OFF_X:  off_x_q  <= quo_d;
        DIV_Y: begin
          q_y_q <= quo_d;
          r_y_q <= rem_d;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: a stage loads when it or any stage after it has room
  // ---------------------------------------------------------------------------
  logic [NST-1:0] v_q, v_in, load;
  logic           accept;
  logic           op_h_q;

  always_comb begin
    load[NST-1] = ~v_q[NST-1] | m_tready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      load[k] = ~v_q[k] | load[k+1];
    end
  end

  assign s_tready_o = load[0] & ~busy;
  assign accept     = s_tvalid_i & s_tready_o;

  always_comb begin
    v_in[0] = accept;
    for (int k = 1; k < NST; k++) begin
      v_in[k] = v_q[k-1];
    end
    v_in[ST_O] = v_q[ST_H] & op_h_q;   // writes leave no result
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (load[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: unpack, products, write address
  // ---------------------------------------------------------------------------
  logic [9:0]  in_src_x;
  logic [8:0]  in_src_y;
  logic [23:0] in_src_rgb;
  logic [11:0] in_dst_x, in_dst_y;
  logic [12:0] in_dy_odd;

  assign in_src_x   = s_tdata_i[9:0];
  assign in_src_y   = s_tdata_i[18:10];
  assign in_src_rgb = s_tdata_i[42:19];
  assign in_dst_x   = s_tdata_i[54:43];
  assign in_dst_y   = s_tdata_i[66:55];
  assign in_dy_odd  = {in_dst_y, 1'b1};

  side_t            side_q [DIV_STAGES+1];
  logic [PXW-1:0]   px_q   [DIV_STAGES+1];
  logic [PYW-1:0]   py_q   [DIV_STAGES+1];
  logic [CFG_W-1:0] drem_q [DIV_STAGES+1];
  logic [CFG_W-1:0] dlo_q  [DIV_STAGES+1];
  logic [QW-1:0]    dquo_q [DIV_STAGES+1];
  logic [25:0]      m_prod;

  assign m_prod = 26'(in_dy_odd) * 26'(r_y_q);

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      side_q[0].op    <= s_tuser_i[0];
      side_q[0].wen   <= (s_tuser_i[0] == OP_WRITE) && (32'(in_src_x) < SRC_WIDTH)
                         && (32'(in_src_y) < SRC_HEIGHT);
      side_q[0].waddr <= AW'(AW'(in_src_y) * AW'(SRC_WIDTH) + AW'(in_src_x));
      side_q[0].wdata <= in_src_rgb;
      px_q[0]         <= PXW'(in_dst_x) * PXW'(step_x_q);
      py_q[0]         <= PYW'(in_dy_odd) * PYW'(q_y_q);
      drem_q[0]       <= m_prod[25:13];
      dlo_q[0]        <= m_prod[12:0];
      dquo_q[0]       <= '0;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 1..13: pipelined divide of the row remainder term by the height
  // ---------------------------------------------------------------------------
  for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
    logic [CFG_W:0] tr;
    logic           tge;
    assign tr  = {drem_q[g-1], dlo_q[g-1][CFG_W-1]};
    assign tge = (tr >= {1'b0, h_eff});
    always_ff @(posedge clk_i) begin
      if (load[g]) begin
        side_q[g] <= side_q[g-1];
        px_q[g]   <= px_q[g-1];
        py_q[g]   <= py_q[g-1];
        drem_q[g] <= tge ? CFG_W'(tr - {1'b0, h_eff}) : tr[CFG_W-1:0];
        dlo_q[g]  <= {dlo_q[g-1][CFG_W-2:0], 1'b0};
        dquo_q[g] <= {dquo_q[g-1][QW-2:0], tge};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage F: source positions plus half a pixel
  // ---------------------------------------------------------------------------
  side_t          side_f_q;
  logic [SXW-1:0] sx_f_q;
  logic [SYW-1:0] sy_f_q;

  always_ff @(posedge clk_i) begin
    if (load[ST_F]) begin
      side_f_q <= side_q[DIV_STAGES];
      sx_f_q   <= SXW'(px_q[DIV_STAGES]) + SXW'(off_x_q);
      sy_f_q   <= SYW'(py_q[DIV_STAGES]) + SYW'(dquo_q[DIV_STAGES]);
    end
  end

  // ---------------------------------------------------------------------------
  // stage C: remove the half pixel, clamp, split into neighbours and weights
  // ---------------------------------------------------------------------------
  logic [SXW-1:0] tx, cx;
  logic [SYW-1:0] ty, cy;
  logic [XW-1:0]  x0_c;
  logic [YW-1:0]  y0_c;

  always_comb begin
    tx = sx_f_q - HALF_X;
    ty = sy_f_q - HALF_Y;
    if (sx_f_q < HALF_X)  cx = '0;
    else if (tx > MAX_X)  cx = MAX_X;
    else                  cx = tx;
    if (sy_f_q < HALF_Y)  cy = '0;
    else if (ty > MAX_Y)  cy = MAX_Y;
    else                  cy = ty;
    x0_c = cx[XW+15:16];
    y0_c = cy[YW+15:16];
  end

  side_t         side_c_q;
  logic [XW-1:0] x0_c_q, x1_c_q;
  logic [YW-1:0] y0_c_q, y1_c_q;
  logic [7:0]    wx_c_q, wy_c_q;

  always_ff @(posedge clk_i) begin
    if (load[ST_C]) begin
      side_c_q <= side_f_q;
      x0_c_q   <= x0_c;
      y0_c_q   <= y0_c;
      x1_c_q   <= (x0_c == XW'(SRC_WIDTH - 1))  ? x0_c : x0_c + XW'(1);
      y1_c_q   <= (y0_c == YW'(SRC_HEIGHT - 1)) ? y0_c : y0_c + YW'(1);
      wx_c_q   <= cx[15:8];
      wy_c_q   <= cy[15:8];
    end
  end

  // ---------------------------------------------------------------------------
  // stage A: row base addresses
  // ---------------------------------------------------------------------------
  side_t         side_a_q;
  logic [AW-1:0] row0_a_q, row1_a_q;
  logic [XW-1:0] x0_a_q, x1_a_q;
  logic [7:0]    wx_a_q, wy_a_q;

  always_ff @(posedge clk_i) begin
    if (load[ST_A]) begin
      side_a_q <= side_c_q;
      row0_a_q <= AW'(AW'(y0_c_q) * AW'(SRC_WIDTH));
      row1_a_q <= AW'(AW'(y1_c_q) * AW'(SRC_WIDTH));
      x0_a_q   <= x0_c_q;
      x1_a_q   <= x1_c_q;
      wx_a_q   <= wx_c_q;
      wy_a_q   <= wy_c_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage M: four image copies, written in the same stage that reads them so
  // items keep their order against the store
  // ---------------------------------------------------------------------------
  logic [AW-1:0] raddr [4];
  logic [23:0]   rdata [4];
  logic          mem_we;

  assign raddr[0] = row0_a_q + AW'(x0_a_q);
  assign raddr[1] = row0_a_q + AW'(x1_a_q);
  assign raddr[2] = row1_a_q + AW'(x0_a_q);
  assign raddr[3] = row1_a_q + AW'(x1_a_q);
  assign mem_we   = load[ST_M] & v_q[ST_A] & side_a_q.wen;

  for (genvar n = 0; n < 4; n++) begin : g_mem
    bilup_ram #(
      .WIDTH (24),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (mem_we),
      .waddr_i (side_a_q.waddr),
      .wdata_i (side_a_q.wdata),
      .re_i    (load[ST_M]),
      .raddr_i (raddr[n]),
      .rdata_o (rdata[n])
    );
  end

  logic       op_m_q;
  logic [7:0] wx_m_q, wy_m_q;

  always_ff @(posedge clk_i) begin
    if (load[ST_M]) begin
      op_m_q <= side_a_q.op;
      wx_m_q <= wx_a_q;
      wy_m_q <= wy_a_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage H: horizontal blend of both rows
  // ---------------------------------------------------------------------------
  logic [23:0] top_h_q, bot_h_q;
  logic [7:0]  wy_h_q;

  always_ff @(posedge clk_i) begin
    if (load[ST_H]) begin
      op_h_q  <= op_m_q;
      top_h_q <= blend(rdata[0], rdata[1], wx_m_q);
      bot_h_q <= blend(rdata[2], rdata[3], wx_m_q);
      wy_h_q  <= wy_m_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage O: vertical blend into the output register
  // ---------------------------------------------------------------------------
  logic [31:0] out_q;

  always_ff @(posedge clk_i) begin
    if (load[ST_O]) begin
      out_q <= ALPHA | {8'h00, blend(top_h_q, bot_h_q, wy_h_q)};
    end
  end

  assign m_tvalid_o = v_q[ST_O];
  assign m_tdata_o  = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_tready_o) else $error("item taken while factors are recomputed");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q && !m_tready_i) |-> !s_tready_o) else $error("item taken into a full pipeline");

  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && $past(load[ST_O]) && $past(v_in[ST_O])) |-> (m_tdata_o[31:24] == 8'hFF))
    else $error("result without opaque alpha");

  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy) |-> (cnt_q == '0)) else $error("divider count running while idle");

endmodule

`default_nettype wire

>>> verif/bilinear_image_upscaler_tb.sv
// self-checking testbench for the bilinear image upscaler: directed and random pixel traffic
`default_nettype none

module bilinear_image_upscaler_tb;
  import bilup_pkg::*;

  localparam int unsigned SW = SRC_WIDTH_DEF;
  localparam int unsigned SH = SRC_HEIGHT_DEF;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic        op;
    logic [9:0]  src_x;
    logic [8:0]  src_y;
    logic [23:0] src_rgb;
    logic [11:0] dst_x;
    logic [11:0] dst_y;
  } pix_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [71:0] s_tdata_i;
  logic [0:0]  s_tuser_i;
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [31:0] m_tdata_o;
  logic        psel_i;
  logic        penable_i;
  logic        pwrite_i;
  logic [2:0]  paddr_i;
  logic [31:0] pwdata_i;
  logic [31:0] prdata_o;
  logic        pready_o;

  bilinear_image_upscaler i_dut (
    .clk_i, .rst_ni,
    .s_tvalid_i, .s_tready_o, .s_tdata_i, .s_tuser_i,
    .m_tvalid_o, .m_tready_i, .m_tdata_o,
    .psel_i, .penable_i, .pwrite_i, .paddr_i, .pwdata_i, .prdata_o, .pready_o
  );

  // pending stimulus, expected pixels, and the mirror of the block's state
  pix_item_t   pend_q[$];
  logic [31:0] pixel_q[$];
  logic [23:0] img_mirror [0:SW*SH-1];
  bit          planned_wr [0:SW*SH-1];
  logic [12:0] cur_w;
  logic [12:0] cur_h;

  int unsigned n_err, n_wr, n_rd, n_res, n_cfg, quiet_cnt;
  int unsigned in_gap, out_gap;
  bit          calm;
  bit          last_taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // map a destination pixel into source space: neighbour columns and rows plus weights
  function automatic void map_dst(input int unsigned dx, input int unsigned dy,
                                  input int unsigned w, input int unsigned h,
                                  output int unsigned x0, output int unsigned x1,
                                  output int unsigned y0, output int unsigned y1,
                                  output logic [7:0] wx, output logic [7:0] wy);
    longint ww, hh, stepx, fx, fy;
    ww = (w == 0) ? 1 : w;
    hh = (h == 0) ? 1 : h;
    stepx = (longint'(SW) * 65536) / ww;
    fx = (longint'(SW) * 32768) / ww - 32768 + longint'(dx) * stepx;
    fy = ((2 * longint'(dy) + 1) * SH * 32768) / hh - 32768;
    if (fx < 0) fx = 0;
    if (fx > longint'(SW - 1) * 65536) fx = longint'(SW - 1) * 65536;
    if (fy < 0) fy = 0;
    if (fy > longint'(SH - 1) * 65536) fy = longint'(SH - 1) * 65536;
    x0 = int'(fx >> 16);
    y0 = int'(fy >> 16);
    x1 = (x0 + 1 < SW) ? x0 + 1 : x0;
    y1 = (y0 + 1 < SH) ? y0 + 1 : y0;
    wx = fx[15:8];
    wy = fy[15:8];
  endfunction

  // per-channel weighted mix, each channel truncated
  function automatic logic [23:0] mix_px(input logic [23:0] p, input logic [23:0] q,
                                         input logic [7:0] wq);
    logic [23:0] r;
    int unsigned wp;
    wp = 256 - wq;
    for (int c = 0; c < 3; c++) begin
      r[c*8 +: 8] = 8'((int'(p[c*8 +: 8]) * wp + int'(q[c*8 +: 8]) * wq) >> 8);
    end
    return r;
  endfunction

  // apply one accepted item to the mirror; reads queue their expected pixel
  function automatic void predict_item(input pix_item_t it);
    int unsigned x0, x1, y0, y1;
    logic [7:0]  wx, wy;
    logic [23:0] top, bot;
    if (it.op == OP_WRITE) begin
      n_wr++;
      if (it.src_x < SW && it.src_y < SH) img_mirror[it.src_y * SW + it.src_x] = it.src_rgb;
    end else begin
      n_rd++;
      map_dst(it.dst_x, it.dst_y, cur_w, cur_h, x0, x1, y0, y1, wx, wy);
      top = mix_px(img_mirror[y0*SW + x0], img_mirror[y0*SW + x1], wx);
      bot = mix_px(img_mirror[y1*SW + x0], img_mirror[y1*SW + x1], wx);
      pixel_q.push_back(ALPHA | {8'h00, mix_px(top, bot, wy)});
    end
  endfunction

  task automatic add_write(input int unsigned x, input int unsigned y, input logic [23:0] rgb);
    pix_item_t it;
    it = '0;
    it.op = OP_WRITE;
    it.src_x = 10'(x);
    it.src_y = 9'(y);
    it.src_rgb = rgb;
    it.dst_x = 12'($urandom);
    it.dst_y = 12'($urandom);
    if (x < SW && y < SH) planned_wr[y*SW + x] = 1'b1;
    pend_q.push_back(it);
  endtask

  // a read is only issued once all four of its neighbours have been written
  task automatic add_read(input int unsigned dx, input int unsigned dy);
    pix_item_t   it;
    int unsigned x0, x1, y0, y1;
    logic [7:0]  wx, wy;
    map_dst(dx, dy, cur_w, cur_h, x0, x1, y0, y1, wx, wy);
    if (!planned_wr[y0*SW + x0]) add_write(x0, y0, 24'($urandom));
    if (!planned_wr[y0*SW + x1]) add_write(x1, y0, 24'($urandom));
    if (!planned_wr[y1*SW + x0]) add_write(x0, y1, 24'($urandom));
    if (!planned_wr[y1*SW + x1]) add_write(x1, y1, 24'($urandom));
    it = '0;
    it.op = OP_READ;
    it.src_x = 10'($urandom);
    it.src_y = 9'($urandom);
    it.src_rgb = 24'($urandom);
    it.dst_x = 12'(dx);
    it.dst_y = 12'(dy);
    pend_q.push_back(it);
  endtask

  task automatic drain_all();
    while (pend_q.size() != 0 || pixel_q.size() != 0) @(posedge clk_i);
    // writes give no result, so allow the pipeline to empty before touching registers
    repeat (30) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic idx, input logic [12:0] val);
    @(negedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= {idx, 2'b00};
    pwdata_i  <= {19'd0, val};
    @(negedge clk_i);
    penable_i <= 1'b1;
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    if (idx == REG_OUT_WIDTH) cur_w = val;
    else cur_h = val;
    n_cfg++;
  endtask

  // random traffic: mostly reads of fresh or rewritten neighbours, some stray writes
  task automatic random_phase(input int unsigned count);
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1: add_write($urandom_range(0, 1023), $urandom_range(0, 511), 24'($urandom));
        2:    add_write($urandom_range(0, SW-1), $urandom_range(0, SH-1), 24'($urandom));
        3:    add_read($urandom_range(0, 4095), $urandom_range(0, 4095));
        default: begin
          // stay inside the configured frame most of the time
          add_read($urandom_range(0, (cur_w > 1) ? cur_w - 1 : 0),
                   $urandom_range(0, (cur_h > 1) ? cur_h - 1 : 0));
        end
      endcase
    end
  endtask

  // stimulus and phase sequencing
  initial begin
    logic [12:0] cfg_w_set [6];
    logic [12:0] cfg_h_set [6];
    s_tvalid_i = 1'b0;
    s_tdata_i  = '0;
    s_tuser_i  = '0;
    m_tready_i = 1'b0;
    psel_i     = 1'b0;
    penable_i  = 1'b0;
    pwrite_i   = 1'b0;
    paddr_i    = '0;
    pwdata_i   = '0;
    cur_w      = OUT_WIDTH_RST;
    cur_h      = OUT_HEIGHT_RST;
    calm       = 1'b0;
    rst_ni     = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extreme colours, corners, stray writes, far reads
    add_write(0, 0, 24'h000000);
    add_write(SW-1, SH-1, 24'hFFFFFF);
    add_write(1023, 511, 24'hFFFFFF);
    add_write(SW, 0, 24'h123456);
    add_write(0, SH, 24'h654321);
    add_read(0, 0);
    add_read(4095, 4095);
    add_read(4095, 0);
    add_read(0, 4095);
    add_read(639, 479);
    add_read(640, 480);
    add_read(320, 240);
    add_write(SW-1, SH-1, 24'h00FF00);
    add_read(4095, 4095);
    add_read(1, 1);
    drain_all();

    cfg_w_set = '{13'd1, 13'd0, 13'd4096, 13'd8191, 13'd1280, 13'(13'h1FFF & $urandom_range(2, 700))};
    cfg_h_set = '{13'd1, 13'd0, 13'd4096, 13'd8191, 13'd960, 13'(13'h1FFF & $urandom_range(2, 700))};
    random_phase(50);
    drain_all();
    for (int p = 0; p < 6; p++) begin
      reg_write(REG_OUT_WIDTH, cfg_w_set[p]);
      reg_write(REG_OUT_HEIGHT, cfg_h_set[p]);
      if (p == 5) calm = 1'b1;
      random_phase(40);
      drain_all();
    end

    $display("covered %0d source writes and %0d pixel reads over %0d register writes,",
             n_wr, n_rd, n_cfg);
    $display("  including degenerate, maximum and out-of-range output sizes; %0d pixels checked",
             n_res);
    if (n_err == 0) begin
      $display("bilinear_image_upscaler_tb: PASS");
    end else begin
      $display("bilinear_image_upscaler_tb: FAIL");
    end
    $finish;
  end

  // input driver: hold an item until taken, idle in random bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && !last_taken) begin
        s_tvalid_i <= 1'b1;
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        s_tvalid_i <= 1'b0;
      end else if (!calm && pend_q.size() != 0 && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(1, 10) - 1;
        s_tvalid_i <= 1'b0;
      end else if (pend_q.size() != 0) begin
        s_tvalid_i <= 1'b1;
        s_tdata_i  <= {5'd0, pend_q[0].dst_y, pend_q[0].dst_x, pend_q[0].src_rgb,
                       pend_q[0].src_y, pend_q[0].src_x};
        s_tuser_i  <= pend_q[0].op;
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // result receiver: stall in random bursts
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      m_tready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(1, 10) - 1;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  // acceptance, prediction, result check and stall watchdog
  always @(posedge clk_i) begin
    logic [31:0] want;
    bit          moved;
    moved = 1'b0;
    last_taken = 1'b0;
    if (rst_ni && s_tvalid_i && s_tready_o) begin
      predict_item(pend_q.pop_front());
      last_taken = 1'b1;
      moved = 1'b1;
    end
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      moved = 1'b1;
      n_res++;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel %08h", $time, m_tdata_o);
        n_err++;
      end else begin
        want = pixel_q.pop_front();
        if (m_tdata_o !== want) begin
          $display("%0t: out_pixel mismatch, expected %08h actual %08h", $time, want, m_tdata_o);
          n_err++;
        end
      end
    end
    if (moved || (pend_q.size() == 0 && pixel_q.size() == 0)) begin
      quiet_cnt = 0;
    end else begin
      quiet_cnt++;
    end
    if (quiet_cnt >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d items pending, %0d pixels awaited",
               $time, quiet_cnt, pend_q.size(), pixel_q.size());
      $display("bilinear_image_upscaler_tb: FAIL");
      $finish;
    end
  end

endmodule

`default_nettype wire
